// ----- src/prc_pkg.sv -----
// Package for the polygon rectangle clipper: constants, types and states.
`timescale 1ns / 1ps
package prc_pkg;
	localparam int COORD_BITS_DEF = 16;
	localparam int T_FRAC_BITS_DEF = 16;

	// Configuration register indexes.
	localparam logic [1:0] REG_X_MIN = 2'd0;
	localparam logic [1:0] REG_X_MAX = 2'd1;
	localparam logic [1:0] REG_Y_MIN = 2'd2;
	localparam logic [1:0] REG_Y_MAX = 2'd3;

	// Input operation codes.
	localparam logic OP_PRIME = 1'b0;
	localparam logic OP_EDGE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV_TXOUT,
		ST_DIV_TYOUT,
		ST_DIV_TXIN,
		ST_DIV_TYIN,
		ST_DECIDE,
		ST_MUL,
		ST_FIN,
		ST_EMIT
	} prc_state_t;

	// Which Liang-Barsky parameter a division produces.
	typedef enum logic [1:0] {
		DSEL_TXOUT,
		DSEL_TYOUT,
		DSEL_TXIN,
		DSEL_TYIN
	} prc_dsel_t;
endpackage

// ----- src/polygon_rect_clipper.sv -----
// Top level of the polygon rectangle clipper with its shared serial divider.
//
// Channel   Handshake               Payload
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
// in        in_valid / in_ready     op, vert_x, vert_y
// out       out_valid / out_ready   out_x, out_y, run_last
//
// A priming request is taken without leaving the idle state, so the block stays ready.
// An edge request passes a setup state, then four divisions through one restoring
// divider; a zero delta skips its division and gives a sentinel instead.
// A decide state, up to two lerp steps (multiply, then finish) and the output
// vertices follow, one vertex per cycle while out_ready is high.
// Reset clears control state, the window and the held vertex.
// The block holds in_ready low while an edge is in work; output stalls hold it.
`timescale 1ns / 1ps
module polygon_rect_clipper import prc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic signed [COORD_BITS-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic signed [COORD_BITS-1:0] vert_x,
	input  logic signed [COORD_BITS-1:0] vert_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic                         run_last
);
	// Widths: deltas take one more bit, t values carry a wide sentinel range.
	localparam int DW = COORD_BITS + 1;
	localparam int NW = DW + T_FRAC_BITS + 1;
	localparam int TW = NW + 3;
	localparam int QB = NW;
	localparam int CW = $clog2(QB + 1);
	localparam int PW = TW + DW;
	localparam logic signed [TW-1:0] T_HI = TW'(1) <<< (TW - 2);
	localparam logic signed [TW-1:0] T_LO = -T_HI;
	localparam logic signed [TW-1:0] T_ONE = TW'(1) <<< T_FRAC_BITS;
	localparam logic signed [TW-1:0] T_ZERO = '0;

	prc_state_t state_q, state_d;

	logic signed [COORD_BITS-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic signed [COORD_BITS-1:0] x1_q, y1_q, x2_q, y2_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic signed [COORD_BITS-1:0] xin_q, xout_q, yin_q, yout_q;
	logic signed [TW-1:0] txout_q, tyout_q, txin_q, tyin_q;

	// Divider registers.
	logic [NW-1:0] dnum_q;
	logic [DW-1:0] dden_q;
	logic [NW:0] drem_q;
	logic [NW-1:0] dquo_q;
	logic [CW-1:0] dcnt_q;
	logic dneg_q, dbusy_q, dstart;

	// Output vertex list, up to three entries.
	logic signed [COORD_BITS-1:0] vx_q [3];
	logic signed [COORD_BITS-1:0] vy_q [3];
	logic [1:0] vk_q, vidx_q;
	// Lerp jobs: which slots need an interpolated coordinate.
	logic [2:0] lerp_q;
	logic [2:0] lerpy_q;
	logic signed [TW-1:0] lt_q [3];
	logic [1:0] lslot_q;
	logic signed [PW-1:0] prod_q;
	logic lyax_q;

	// Configuration is always accepted.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= '0;
			x_max_q <= '0;
			y_min_q <= '0;
			y_max_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_X_MIN: x_min_q <= cfg_data;
				REG_X_MAX: x_max_q <= cfg_data;
				REG_Y_MIN: y_min_q <= cfg_data;
				REG_Y_MAX: y_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	wire in_acc = in_valid && in_ready;

	// Divider operand selection by state.
	logic signed [DW-1:0] num_sel, den_sel;
	prc_dsel_t dsel;
	always_comb begin
		unique case (state_q)
			ST_DIV_TXOUT: dsel = DSEL_TXOUT;
			ST_DIV_TYOUT: dsel = DSEL_TYOUT;
			ST_DIV_TXIN:  dsel = DSEL_TXIN;
			default:      dsel = DSEL_TYIN;
		endcase
		unique case (dsel)
			DSEL_TXOUT: begin
				num_sel = DW'(xout_q) - DW'(x1_q);
				den_sel = dx_q;
			end
			DSEL_TYOUT: begin
				num_sel = DW'(yout_q) - DW'(y1_q);
				den_sel = dy_q;
			end
			DSEL_TXIN: begin
				num_sel = DW'(xin_q) - DW'(x1_q);
				den_sel = dx_q;
			end
			default: begin
				num_sel = DW'(yin_q) - DW'(y1_q);
				den_sel = dy_q;
			end
		endcase
	end
	wire dzero = (den_sel == '0);
	wire [DW-1:0] num_abs = num_sel[DW-1] ? DW'(-num_sel) : DW'(num_sel);
	wire [DW-1:0] den_abs = den_sel[DW-1] ? DW'(-den_sel) : DW'(den_sel);

	// Dividend is (|num| << F) + |den|/2, computed in one add.
	wire [NW-1:0] dividend = (NW'(num_abs) << T_FRAC_BITS) + NW'(den_abs >> 1);

	// Restoring divider step.
	wire [NW:0] rem_sh = {drem_q[NW-1:0], dnum_q[NW-1]};
	wire [NW:0] rem_sub = rem_sh - (NW+1)'(dden_q);
	wire rem_ge = !rem_sub[NW];
	wire ddone = dbusy_q && (dcnt_q == '0);
	wire signed [TW-1:0] qsgn = dneg_q ? -TW'(dquo_q) : TW'(dquo_q);

	// Sentinel for a zero delta in the current division.
	logic signed [TW-1:0] sent;
	always_comb begin
		unique case (dsel)
			DSEL_TXOUT: sent = (x1_q >= x_min_q && x1_q <= x_max_q) ? T_HI : T_LO;
			DSEL_TYOUT: sent = (y1_q >= y_min_q && y1_q <= y_max_q) ? T_HI : T_LO;
			default:    sent = T_LO;
		endcase
	end

	wire in_div = (state_q == ST_DIV_TXOUT) || (state_q == ST_DIV_TYOUT) ||
		(state_q == ST_DIV_TXIN) || (state_q == ST_DIV_TYIN);
	assign dstart = in_div && !dbusy_q && !dzero;
	wire div_fin = in_div && ((!dbusy_q && dzero) || ddone);
	wire signed [TW-1:0] t_res = dbusy_q ? qsgn : sent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			dcnt_q <= '0;
		end else if (dstart) begin
			dbusy_q <= 1'b1;
			dcnt_q <= CW'(QB);
		end else if (ddone) begin
			dbusy_q <= 1'b0;
		end else if (dbusy_q) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	// Divider datapath.
	always_ff @(posedge clk) begin
		if (dstart) begin
			dnum_q <= dividend;
			dden_q <= den_abs;
			drem_q <= '0;
			dquo_q <= '0;
			dneg_q <= num_sel[DW-1] ^ den_sel[DW-1];
		end else if (dbusy_q && !ddone) begin
			dnum_q <= dnum_q << 1;
			drem_q <= rem_ge ? rem_sub : rem_sh;
			dquo_q <= {dquo_q[NW-2:0], rem_ge};
		end
	end

	// Decision on the four parameters.
	wire x_lt = txout_q < tyout_q;
	wire signed [TW-1:0] t1out = x_lt ? txout_q : tyout_q;
	wire signed [TW-1:0] t2out = x_lt ? tyout_q : txout_q;
	wire in_lt = txin_q < tyin_q;
	wire signed [TW-1:0] t2in = in_lt ? tyin_q : txin_q;

	// Lerp: product of t and delta, then round and add.
	wire [1:0] next_slot = lerp_q[0] ? 2'd0 : (lerp_q[1] ? 2'd1 : 2'd2);
	wire signed [PW-1:0] v_rnd = prod_q + PW'(T_ONE >>> 1);
	wire signed [PW-1:0] v_neg = -v_rnd;
	wire signed [PW-1:0] q_pos = v_rnd >>> T_FRAC_BITS;
	wire signed [PW-1:0] q_negm = (v_neg + PW'(T_ONE - 1)) >>> T_FRAC_BITS;
	wire signed [PW-1:0] q_val = v_rnd[PW-1] ? -q_negm : q_pos;
	wire signed [COORD_BITS-1:0] l_base = lyax_q ? y1_q : x1_q;
	wire signed [COORD_BITS-1:0] l_res = l_base + COORD_BITS'(q_val);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_acc) state_d = (op == OP_EDGE) ? ST_SETUP : ST_IDLE;
			ST_SETUP:     state_d = ST_DIV_TXOUT;
			ST_DIV_TXOUT: if (div_fin) state_d = ST_DIV_TYOUT;
			ST_DIV_TYOUT: if (div_fin) state_d = ST_DIV_TXIN;
			ST_DIV_TXIN:  if (div_fin) state_d = ST_DIV_TYIN;
			ST_DIV_TYIN:  if (div_fin) state_d = ST_DECIDE;
			ST_DECIDE:    state_d = ST_MUL;
			ST_MUL:       state_d = (lerp_q == '0) ? ST_EMIT : ST_FIN;
			ST_FIN:       state_d = ST_MUL;
			ST_EMIT: begin
				if (vk_q == '0) state_d = ST_IDLE;
				else if (out_ready && (vidx_q == vk_q - 1'b1)) state_d = ST_IDLE;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Held vertex and edge setup.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			y1_q <= '0;
			x2_q <= '0;
			y2_q <= '0;
		end else if (in_acc) begin
			x1_q <= x2_q;
			y1_q <= y2_q;
			x2_q <= vert_x;
			y2_q <= vert_y;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			dx_q <= DW'(x2_q) - DW'(x1_q);
			dy_q <= DW'(y2_q) - DW'(y1_q);
			if ((x2_q > x1_q) || ((x2_q == x1_q) && (x1_q > x_max_q))) begin
				xin_q <= x_min_q;
				xout_q <= x_max_q;
			end else begin
				xin_q <= x_max_q;
				xout_q <= x_min_q;
			end
			if ((y2_q > y1_q) || ((y2_q == y1_q) && (y1_q > y_max_q))) begin
				yin_q <= y_min_q;
				yout_q <= y_max_q;
			end else begin
				yin_q <= y_max_q;
				yout_q <= y_min_q;
			end
		end
		if (div_fin) begin
			case (dsel)
				DSEL_TXOUT: txout_q <= t_res;
				DSEL_TYOUT: tyout_q <= t_res;
				DSEL_TXIN:  txin_q <= t_res;
				default:    tyin_q <= t_res;
			endcase
		end
	end

	// Vertex list build, lerp fill-in and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vk_q <= '0;
			vidx_q <= '0;
			lerp_q <= '0;
		end else begin
			unique case (state_q)
				ST_DECIDE: begin
					logic [1:0] k;
					logic [2:0] lmask;
					k = '0;
					lmask = '0;
					vidx_q <= '0;
					if (t2out > T_ZERO) begin
						if (t1out < t2in) begin
							if (t1out > T_ZERO && t1out <= T_ONE) begin
								vx_q[k] <= in_lt ? xout_q : xin_q;
								vy_q[k] <= in_lt ? yin_q : yout_q;
								k = k + 1'b1;
							end
						end else if (t1out > T_ZERO && t2in <= T_ONE) begin
							if (t2in >= T_ZERO) begin
								lmask[k] = 1'b1;
								if (txin_q > tyin_q) begin
									vx_q[k] <= xin_q;
									lerpy_q[k] <= 1'b1;
									lt_q[k] <= txin_q;
								end else begin
									vy_q[k] <= yin_q;
									lerpy_q[k] <= 1'b0;
									lt_q[k] <= tyin_q;
								end
								k = k + 1'b1;
							end
							if (t1out <= T_ONE) begin
								lmask[k] = 1'b1;
								if (x_lt) begin
									vx_q[k] <= xout_q;
									lerpy_q[k] <= 1'b1;
									lt_q[k] <= txout_q;
								end else begin
									vy_q[k] <= yout_q;
									lerpy_q[k] <= 1'b0;
									lt_q[k] <= tyout_q;
								end
							end else begin
								vx_q[k] <= x2_q;
								vy_q[k] <= y2_q;
							end
							k = k + 1'b1;
						end
						if (t2out <= T_ONE) begin
							vx_q[k] <= xout_q;
							vy_q[k] <= yout_q;
							k = k + 1'b1;
						end
					end
					lerp_q <= lmask;
					vk_q <= k;
				end
				ST_MUL: begin
					lslot_q <= next_slot;
					lyax_q <= lerpy_q[next_slot];
					prod_q <= PW'(lt_q[next_slot]) *
						PW'(lerpy_q[next_slot] ? dy_q : dx_q);
				end
				ST_FIN: begin
					lerp_q[lslot_q] <= 1'b0;
					if (lyax_q) vy_q[lslot_q] <= l_res;
					else vx_q[lslot_q] <= l_res;
				end
				ST_EMIT: if (out_ready && vk_q != '0) vidx_q <= vidx_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Output drive.
	always_comb begin
		out_valid = (state_q == ST_EMIT) && (vk_q != '0);
		out_x = vx_q[vidx_q];
		out_y = vy_q[vidx_q];
		run_last = (vidx_q == vk_q - 1'b1);
	end

	// The divider only runs during a division state.
	assert property (@(posedge clk) disable iff (!arst_n) dbusy_q |-> in_div)
		else $error("divider busy outside a division state");
	// No new request is taken while output is pending.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready)
		else $error("input ready while output pending");
	// At most three vertices per edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (vk_q != 2'd3 || vidx_q <= 2'd2))
		else $error("vertex index out of range");
endmodule
